// ----- design/adsr_pkg.sv -----
package adsr_pkg;

  // Default fraction width of levels and steps
  localparam int FRAC_BITS_DEFAULT = 24;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 3'd3;

  // Step values after reset
  localparam int ATTACK_STEP_RESET  = 3495;
  localparam int DECAY_STEP_RESET   = 3495;
  localparam int RELEASE_STEP_RESET = 1398;

  // Stage codes as shown on the result channel
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PHASE_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_ATTACK  = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_DECAY   = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_SUSTAIN = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_RELEASE = 3'd4;

  // Envelope stage, one-hot
  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_ATTACK  = 5'b00010,
    ST_DECAY   = 5'b00100,
    ST_SUSTAIN = 5'b01000,
    ST_RELEASE = 5'b10000
  } stage_t;

  // Map a stage to its result code
  function automatic logic [PHASE_W-1:0] phase_code(input stage_t st);
    logic [PHASE_W-1:0] code;
    case (st)
      ST_ATTACK:  code = PHASE_ATTACK;
      ST_DECAY:   code = PHASE_DECAY;
      ST_SUSTAIN: code = PHASE_SUSTAIN;
      ST_RELEASE: code = PHASE_RELEASE;
      default:    code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ----- design/adsr_if.sv -----
// Gate channel: one gate bit per sample tick
interface adsr_in_if;
  logic valid;
  logic ready;
  logic gate;

  modport source (output valid, output gate, input ready);
  modport sink   (input valid, input gate, output ready);
endinterface

// Result channel: envelope level and stage after each tick
interface adsr_out_if #(
  parameter int W = adsr_pkg::FRAC_BITS_DEFAULT + 1
);
  logic                          valid;
  logic                          ready;
  logic [W-1:0]                  level;
  logic [adsr_pkg::PHASE_W-1:0]  phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink   (input valid, input level, input phase, output ready);
endinterface

// ----- design/adsr_envelope_generator_top.sv -----
// Linear ADSR envelope generator. Each transaction on in_ch is one sample tick
// carrying the gate level; each tick produces exactly one transaction on out_ch
// with the envelope level (unsigned, FRAC_BITS fraction bits, full scale
// 2^FRAC_BITS) and the stage after that tick. A tick is accepted each cycle that
// in_ch.ready is high and its result is registered: the whole stage update
// (one add or subtract, a saturating compare and the stage choice) sits
// between the envelope state registers and the result register. A two-entry
// output stage (result register plus skid register) keeps in_ch.ready high as
// long as fewer than two results wait on out_ch. Registers are written through
// cfg_wen/cfg_index/cfg_data: 0 attack step, 1 decay step, 2 sustain level,
// 3 release step; other indexes are ignored. Write them only while no tick is
// in flight.
module adsr_envelope_generator_top #(
  parameter int FRAC_BITS = adsr_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [FRAC_BITS:0]                 cfg_data,
  adsr_in_if.sink                            in_ch,
  adsr_out_if.source                         out_ch
);

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE_LVL  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W:0]   ONE_WIDE = {2'b01, {FRAC_BITS{1'b0}}};

  // Configuration registers
  logic [W-1:0] attack_step;
  logic [W-1:0] decay_step;
  logic [W-1:0] sustain_level;
  logic [W-1:0] release_step;

  // Envelope state
  logic [W-1:0]     envelope;
  adsr_pkg::stage_t stage;
  logic             prev_gate;

  logic [W-1:0]     envelope_next;
  adsr_pkg::stage_t stage_next;

  // Output stage
  logic                          out_valid;
  logic [W-1:0]                  out_level;
  logic [adsr_pkg::PHASE_W-1:0]  out_phase;
  logic                          skid_valid;
  logic [W-1:0]                  skid_level;
  logic [adsr_pkg::PHASE_W-1:0]  skid_phase;

  logic in_fire;
  logic out_fire;

  assign in_ch.ready  = !skid_valid;
  assign in_fire      = in_ch.valid && !skid_valid;
  assign out_fire     = out_valid && out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.level = out_level;
  assign out_ch.phase = out_phase;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_step   <= W'(adsr_pkg::ATTACK_STEP_RESET);
      decay_step    <= W'(adsr_pkg::DECAY_STEP_RESET);
      sustain_level <= {2'b01, {(FRAC_BITS - 1){1'b0}}};
      release_step  <= W'(adsr_pkg::RELEASE_STEP_RESET);
    end else if (cfg_wen) begin
      case (cfg_index)
        adsr_pkg::REG_ATTACK_STEP:  attack_step   <= cfg_data;
        adsr_pkg::REG_DECAY_STEP:   decay_step    <= cfg_data;
        adsr_pkg::REG_SUSTAIN:      sustain_level <= cfg_data;
        adsr_pkg::REG_RELEASE_STEP: release_step  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Compute the next envelope level and stage for one tick
  always_comb begin
    logic [W-1:0]     sus;
    logic [W:0]       att_sum;
    logic [W-1:0]     dec_diff;
    logic [W-1:0]     rel_diff;
    adsr_pkg::stage_t st;

    sus      = (sustain_level > ONE_LVL) ? ONE_LVL : sustain_level;
    att_sum  = {1'b0, envelope} + {1'b0, attack_step};
    dec_diff = (decay_step >= envelope) ? '0 : envelope - decay_step;
    rel_diff = (release_step >= envelope) ? '0 : envelope - release_step;

    // Gate edges act before the stage update
    st = stage;
    if (in_ch.gate && !prev_gate) begin
      st = adsr_pkg::ST_ATTACK;
    end else if (!in_ch.gate && prev_gate && stage == adsr_pkg::ST_SUSTAIN) begin
      st = adsr_pkg::ST_RELEASE;
    end

    envelope_next = envelope;
    stage_next    = st;
    case (st)
      adsr_pkg::ST_ATTACK: begin
        if (att_sum >= ONE_WIDE) begin
          envelope_next = ONE_LVL;
          stage_next    = adsr_pkg::ST_DECAY;
        end else begin
          envelope_next = att_sum[W-1:0];
        end
      end
      adsr_pkg::ST_DECAY: begin
        if (dec_diff <= sus) begin
          envelope_next = sus;
          stage_next    = in_ch.gate ? adsr_pkg::ST_SUSTAIN : adsr_pkg::ST_RELEASE;
        end else begin
          envelope_next = dec_diff;
        end
      end
      adsr_pkg::ST_SUSTAIN: begin
        envelope_next = sus;
        if (!in_ch.gate) begin
          stage_next = adsr_pkg::ST_RELEASE;
        end
      end
      adsr_pkg::ST_RELEASE: begin
        envelope_next = rel_diff;
        if (rel_diff == '0) begin
          stage_next = adsr_pkg::ST_IDLE;
        end
      end
      default: begin
        envelope_next = '0;
        stage_next    = adsr_pkg::ST_IDLE;
      end
    endcase
  end

  // Advance the envelope state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      envelope  <= '0;
      stage     <= adsr_pkg::ST_IDLE;
      prev_gate <= 1'b0;
    end else if (in_fire) begin
      envelope  <= envelope_next;
      stage     <= stage_next;
      prev_gate <= in_ch.gate;
    end
  end

  // Output stage control: result register with a skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_level <= skid_level;
        out_phase <= skid_phase;
      end else begin
        out_level <= envelope_next;
        out_phase <= adsr_pkg::phase_code(stage_next);
      end
    end else if (in_fire) begin
      skid_level <= envelope_next;
      skid_phase <= adsr_pkg::phase_code(stage_next);
    end
  end

endmodule

// ----- design/adsr_chk.sv -----
// Port-level checks for the envelope generator
module adsr_chk #(
  parameter int W = adsr_pkg::FRAC_BITS_DEFAULT + 1
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [W-1:0]                  out_level,
  input logic [adsr_pkg::PHASE_W-1:0]  out_phase
);

  localparam logic [W-1:0] ONE_LVL = {1'b1, {(W - 1){1'b0}}};

  // Level never exceeds full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_level <= ONE_LVL)
    else $error("envelope level above full scale");

  // Idle stage always reports a zero level
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_phase == adsr_pkg::PHASE_IDLE |-> out_level == '0)
    else $error("idle stage with nonzero level");

  // Attack stage stays below full scale; reaching it moves to decay
  a_attack_below_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_phase == adsr_pkg::PHASE_ATTACK |-> out_level < ONE_LVL)
    else $error("attack stage at full scale");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_phase))
    else $error("stalled result changed");

endmodule

bind adsr_envelope_generator_top adsr_chk #(.W(FRAC_BITS + 1)) u_adsr_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_level (out_ch.level),
  .out_phase (out_ch.phase)
);
